// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_SET_CURSOR = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    typedef struct packed {
        op_t               op;
        logic [7:0]        char_code;
        logic signed [7:0] column;
        logic signed [7:0] row;
    } in_t;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// COLS x ROWS text console: cell store in one synchronous RAM plus cursor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------------------------
//  in      | to block  | in_valid / in_ready  | in_t: op, char, column, row
//  out     | from block| out_valid / out_ready| out_t: cursor and read cell
//  cfg     | to block  | cfg_valid / cfg_ready| 8-bit text attribute
//
//  Steps: put, carriage return, line feed and set cursor are accepted, then
//  handed off to the output register; a read also passes ST_READ to pick
//  up the registered RAM read. A scroll walks every cell once and clear
//  writes every cell, both through the single write port of the cell RAM.
//  Reset: after rst_n the RAM is swept to blanks with attribute 07,
//  with in_ready low during the sweep; cfg is always ready.
//  Stalls: the output register holds a finished beat; the next item is
//  taken while it waits, and that item parks its result until the register
//  frees up.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [6:0]        COL_LAST   = 7'(COLS - 1);
    localparam logic [4:0]        ROW_LAST   = 5'(ROWS - 1);
    localparam logic signed [8:0] COL_LAST_S = 9'(COLS - 1);
    localparam logic signed [8:0] ROW_LAST_S = 9'(ROWS - 1);
    localparam logic [AW-1:0]     LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]     SCROLL_END = AW'(CELLS - COLS);

    // cell RAM: char in [7:0], attribute in [15:8]
    logic [15:0]   mem [CELLS];
    logic [15:0]   mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    state_t        state_reg, state_next;
    logic [AW-1:0] sc_reg, sc_next;            // sweep counter
    logic [6:0]    cur_col_reg, cur_col_next;
    logic [4:0]    cur_row_reg, cur_row_next;
    logic [7:0]    attr_reg;
    logic [15:0]   cell_reg, cell_next;        // read result, zero otherwise
    logic          pend_valid_reg, pend_valid_next;
    logic          pend_blank_reg, pend_blank_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;

    logic          accept;
    logic          need_scroll;
    logic          out_free;
    logic signed [8:0] col_s, row_s;
    logic [6:0]    col_clamp;
    logic [4:0]    row_clamp;
    logic [AW:0]   scroll_src;

    function automatic logic [AW-1:0] cell_addr(input logic [6:0] c, input logic [4:0] r);
        return AW'(r) * AW'(COLS) + AW'(c);
    endfunction

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // coordinate clamp
    assign col_s      = {in_data.column[7], in_data.column};
    assign row_s      = {in_data.row[7], in_data.row};
    assign col_clamp  = col_s[8] ? 7'd0 : (col_s > COL_LAST_S) ? COL_LAST : col_s[6:0];
    assign row_clamp  = row_s[8] ? 5'd0 : (row_s > ROW_LAST_S) ? ROW_LAST : row_s[4:0];
    assign scroll_src = (AW + 1)'(sc_reg) + (AW + 1)'(COLS);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sc_reg == LAST_CELL)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.op)
                        OP_CLEAR:      state_next = ST_CLEAR;
                        OP_READ:       state_next = ST_READ;
                        OP_PUT:        state_next = need_scroll ? ST_SCROLL : ST_DONE;
                        OP_SET_CURSOR: state_next = ST_DONE;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_SCROLL:
            begin
                if (sc_reg == LAST_CELL)
                    state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (sc_reg == LAST_CELL)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        need_scroll     = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = sc_reg;
        mem_wdata       = {attr_reg, BLANK_CHAR};
        mem_raddr       = '0;
        sc_next         = sc_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        cell_next       = cell_reg;
        pend_valid_next = 1'b0;
        pend_blank_next = pend_blank_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        // trailing write of the scroll pipeline
        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_blank_reg ? {attr_reg, BLANK_CHAR} : mem_rdata_reg;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = sc_reg;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                sc_next   = sc_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    sc_next   = '0;
                    cell_next = '0;
                    case (in_data.op)
                        OP_PUT:
                        begin
                            if (in_data.char_code == CHAR_LF)
                            begin
                                if (cur_row_reg == ROW_LAST)
                                    need_scroll = 1'b1;
                                else
                                    cur_row_next = cur_row_reg + 1'b1;
                            end
                            else if (in_data.char_code == CHAR_CR)
                            begin
                                cur_col_next = '0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(cur_col_reg, cur_row_reg);
                                mem_wdata = {attr_reg, in_data.char_code};
                                if (cur_col_reg == COL_LAST)
                                begin
                                    cur_col_next = '0;
                                    if (cur_row_reg == ROW_LAST)
                                        need_scroll = 1'b1;
                                    else
                                        cur_row_next = cur_row_reg + 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                        end
                        OP_SET_CURSOR:
                        begin
                            cur_col_next = col_clamp;
                            cur_row_next = row_clamp;
                        end
                        OP_READ:
                        begin
                            mem_raddr = cell_addr(col_clamp, row_clamp);
                        end
                        default:
                        begin
                            cell_next = '0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cell_next = mem_rdata_reg;
            end
            ST_SCROLL:
            begin
                // read row below, write it in the following cycle; last row gets blanks
                pend_valid_next = 1'b1;
                pend_addr_next  = sc_reg;
                pend_blank_next = (sc_reg >= SCROLL_END);
                mem_raddr       = (sc_reg >= SCROLL_END) ? '0 : scroll_src[AW-1:0];
                sc_next         = sc_reg + 1'b1;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sc_reg;
                mem_wdata = {attr_reg, BLANK_CHAR};
                sc_next   = sc_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{cursor_column: cur_col_reg,
                                       cursor_row:    cur_row_reg,
                                       cell_char:     cell_reg[7:0],
                                       cell_attr:     cell_reg[15:8]};
                end
            end
            default:
            begin
                sc_next = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sc_reg         <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            attr_reg       <= RESET_ATTR;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sc_reg         <= sc_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
                attr_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cell_reg       <= cell_next;
        pend_blank_reg <= pend_blank_next;
        pend_addr_reg  <= pend_addr_next;
        out_data_reg   <= out_data_next;
    end

    // cell RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule

// ===== hw/rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input out_t       out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out beat changed while stalled");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.cursor_column <= 7'(COLS - 1))
                   && (out_data.cursor_row <= 5'(ROWS - 1)))
        else $error("cursor off screen");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one in flight");

endmodule

bind text_console_writer tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (.*);

// ===== tb/text_console_writer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the 80x25 text console. A shadow copy of the cell
// store, the cursor and the attribute register predicts every result beat.
// A short scripted pass hits clamping, wrap, scroll, CR/LF and clear. Random
// phases follow, each under a different attribute setting, with both sides
// idling in short bursts. The last phase runs with no idling at all.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    import tcw_pkg::*;

    localparam int SCREEN_COLS    = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_CELLS   = SCREEN_COLS * SCREEN_ROWS;
    localparam int LAST_COL       = SCREEN_COLS - 1;
    localparam int LAST_ROW       = SCREEN_ROWS - 1;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 200;
    // Reset sweep, scroll and clear each hold the block with nothing moving;
    // the limit must outlast the longest of them before giving up.
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int TAIL_CYCLES    = 40;

    // One scripted command; pinned rows carry a hand-typed result.
    typedef struct {
        in_t  cmd;
        bit   pinned;
        out_t res;
    } script_line_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_t        in_data;
    logic       out_valid;
    logic       out_ready;
    out_t       out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // Shadow of the console: cells hold {attribute, character}.
    logic [15:0]  cell_shadow [SCREEN_CELLS];
    int           cur_col;
    int           cur_row;
    logic [7:0]   attr_shadow;
    out_t         console_expected [$];
    script_line_t script [$];

    // Travel with the current input beat so the monitor knows whether a
    // hand-typed result replaces the predicted one.
    bit   pin_now;
    out_t pin_res;

    bit idle_en;
    bit stall_en;
    int idle_pct;

    int error_count;
    int cmd_count;
    int result_count;
    int scroll_count;
    int clear_count;
    int read_count;
    int attr_writes;
    int quiet_cycles;

    text_console_writer #(
        .COLS (SCREEN_COLS),
        .ROWS (SCREEN_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Console predictor
    // ------------------------------------------------------------------

    function automatic int clamp_coord(logic signed [7:0] v, int last);
        int x;
        x = int'(v);
        if (x < 0)
            return 0;
        if (x > last)
            return last;
        return x;
    endfunction

    // Shift every row up one, blank the bottom row with the live attribute.
    function automatic void scroll_shadow();
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            cell_shadow[i] = cell_shadow[i + SCREEN_COLS];
        for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
            cell_shadow[i] = {attr_shadow, BLANK_CHAR};
        cur_row = LAST_ROW;
        scroll_count++;
    endfunction

    function automatic out_t console_step(in_t cmd);
        out_t res;
        int   cc;
        int   rr;
        res = '0;
        cc  = clamp_coord(cmd.column, LAST_COL);
        rr  = clamp_coord(cmd.row, LAST_ROW);
        case (cmd.op)
            OP_PUT:
            begin
                if (cmd.char_code == CHAR_LF)
                begin
                    // line feed keeps the column, may scroll
                    cur_row++;
                    if (cur_row > LAST_ROW)
                        scroll_shadow();
                end
                else if (cmd.char_code == CHAR_CR)
                begin
                    cur_col = 0;
                end
                else
                begin
                    cell_shadow[cur_row * SCREEN_COLS + cur_col] =
                        {attr_shadow, cmd.char_code};
                    cur_col++;
                    if (cur_col > LAST_COL)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row > LAST_ROW)
                        scroll_shadow();
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SCREEN_CELLS; i++)
                    cell_shadow[i] = {attr_shadow, BLANK_CHAR};
                cur_col = 0;
                cur_row = 0;
                clear_count++;
            end
            OP_SET_CURSOR:
            begin
                cur_col = cc;
                cur_row = rr;
            end
            default:
            begin
                // read: cursor untouched
                res.cell_char = cell_shadow[rr * SCREEN_COLS + cc][7:0];
                res.cell_attr = cell_shadow[rr * SCREEN_COLS + cc][15:8];
                read_count++;
            end
        endcase
        res.cursor_column = cur_col[6:0];
        res.cursor_row    = cur_row[4:0];
        return res;
    endfunction

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted command, checks every result
    // beat, and runs the watchdog. All sampling at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_t pred;
        out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                attr_shadow = cfg_data;
                attr_writes++;
            end
            if (in_valid && in_ready)
            begin
                pred = console_step(in_data);
                cmd_count++;
                console_expected.push_back(pin_now ? pin_res : pred);
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                if (console_expected.size() == 0)
                begin
                    $error("result beat with no command outstanding: %p", out_data);
                    error_count++;
                end
                else
                begin
                    want = console_expected.pop_front();
                    check_field("cursor_column", int'(want.cursor_column),
                                int'(out_data.cursor_column));
                    check_field("cursor_row", int'(want.cursor_row),
                                int'(out_data.cursor_row));
                    check_field("cell_char", int'(want.cell_char),
                                int'(out_data.cell_char));
                    check_field("cell_attr", int'(want.cell_attr),
                                int'(out_data.cell_attr));
                end
            end
            // Watchdog: any handshake on any channel counts as progress.
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: out_ready drops in bursts of random length. The stall
    // rate is re-picked after each random span, so there are calm stretches.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_pct;
        int span;
        out_ready = 1'b0;
        stall_pct = 0;
        span      = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span      = $urandom_range(16, 64);
                stall_pct = $urandom_range(0, 2) * 20;
            end
            span--;
            if (stall_en && ($urandom_range(0, 99) < stall_pct))
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
                // a ready cycle always ends the burst
                @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Present one beat at the falling edge, maybe after an idle burst,
    // and hold it until accepted. Valid drops between beats only for idle bursts.
    task automatic send_command(in_t cmd, bit pinned, out_t res);
        @(negedge clk);
        if (idle_en && ($urandom_range(0, 99) < idle_pct))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        pin_now  <= pinned;
        pin_res  <= res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        pin_now  <= 1'b0;
        while (console_expected.size() != 0)
            @(posedge clk);
    endtask

    // Attribute is only changed with the console idle and drained.
    task automatic write_attribute(logic [7:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_line(op_t op, logic [7:0] ch, int col, int row,
                                     bit pinned = 1'b0, int r_col = 0,
                                     int r_row = 0, int r_char = 0,
                                     int r_attr = 0);
        script_line_t ln;
        ln.cmd.op             = op;
        ln.cmd.char_code      = ch;
        ln.cmd.column         = col[7:0];
        ln.cmd.row            = row[7:0];
        ln.pinned             = pinned;
        ln.res.cursor_column  = r_col[6:0];
        ln.res.cursor_row     = r_row[4:0];
        ln.res.cell_char      = r_char[7:0];
        ln.res.cell_attr      = r_attr[7:0];
        script.push_back(ln);
    endfunction

    // Random command mix: mostly text, some cursor moves and reads, rare
    // clears (each one costs a full sweep of the store). Reads lean toward
    // the cursor's neighborhood so freshly written cells get looked at.
    function automatic in_t random_command();
        in_t cmd;
        int  pick;
        cmd.op        = OP_PUT;
        cmd.char_code = 8'($urandom_range(0, 255));
        cmd.column    = 8'($urandom_range(0, 255));
        cmd.row       = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            cmd.op = OP_CLEAR;
        end
        else if (pick < 12)
        begin
            cmd.op = OP_SET_CURSOR;
            if ($urandom_range(0, 3) != 0)
            begin
                cmd.column = 8'($urandom_range(0, LAST_COL));
                cmd.row    = 8'($urandom_range(0, LAST_ROW));
            end
        end
        else if (pick < 30)
        begin
            cmd.op = OP_READ;
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                cmd.column = 8'($urandom_range(0, LAST_COL));
                cmd.row    = 8'((cur_row > 0 && $urandom_range(0, 1)) ? cur_row - 1
                                                                      : cur_row);
            end
            else if (pick < 8)
            begin
                cmd.column = 8'($urandom_range(0, LAST_COL));
                cmd.row    = 8'($urandom_range(0, LAST_ROW));
            end
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                cmd.char_code = CHAR_LF;
            else if (pick < 8)
                cmd.char_code = CHAR_CR;
        end
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [7:0] attr_plan [PHASE_COUNT];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        pin_now     = 1'b0;
        pin_res     = '0;
        idle_en     = 1'b1;
        stall_en    = 1'b1;
        idle_pct    = 25;
        error_count = 0;
        quiet_cycles = 0;

        // shadow matches the post-reset sweep: blanks with attribute 07
        attr_shadow = RESET_ATTR;
        cur_col     = 0;
        cur_row     = 0;
        for (int i = 0; i < SCREEN_CELLS; i++)
            cell_shadow[i] = {RESET_ATTR, BLANK_CHAR};

        // extremes first, then a random mix of settings
        attr_plan[0] = 8'hFF;
        attr_plan[1] = 8'h00;
        attr_plan[2] = 8'($urandom_range(0, 255));
        attr_plan[3] = 8'hA5;
        attr_plan[4] = 8'($urandom_range(0, 255));
        attr_plan[5] = 8'($urandom_range(0, 255));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Scripted pass, reset attribute 07. Pinned rows are obvious from
        // the spec; the rest go through the predictor.
        // reset contents, read clamping at both ends
        add_line(OP_READ, 8'hFF, 0, 0, 1, 0, 0, BLANK_CHAR, RESET_ATTR);
        add_line(OP_READ, CHAR_LF, 127, 127, 1, 0, 0, BLANK_CHAR, RESET_ATTR);
        add_line(OP_READ, 8'h00, -128, -128, 1, 0, 0, BLANK_CHAR, RESET_ATTR);
        // set-cursor clamping
        add_line(OP_SET_CURSOR, CHAR_CR, 127, 127, 1, LAST_COL, LAST_ROW);
        add_line(OP_SET_CURSOR, 8'h00, -128, -128, 1, 0, 0);
        add_line(OP_SET_CURSOR, 8'hFF, -1, LAST_ROW, 1, 0, LAST_ROW);
        // top character code on the bottom row, then CR back
        add_line(OP_PUT, 8'hFF, 55, -7, 1, 1, LAST_ROW);
        add_line(OP_PUT, CHAR_CR, -5, 3, 1, 0, LAST_ROW);
        add_line(OP_READ, 8'h00, 0, LAST_ROW, 1, 0, LAST_ROW, 8'hFF, RESET_ATTR);
        // last cell: wrap past the right edge forces a scroll
        add_line(OP_SET_CURSOR, 8'h00, LAST_COL, LAST_ROW, 1, LAST_COL, LAST_ROW);
        add_line(OP_PUT, 8'h00, 0, 0, 1, 0, LAST_ROW);
        add_line(OP_READ, 8'h41, 0, LAST_ROW - 1);
        add_line(OP_READ, 8'h00, LAST_COL, LAST_ROW - 1);
        add_line(OP_READ, 8'h00, 0, LAST_ROW);
        // line feed on the bottom row scrolls and keeps the column
        add_line(OP_SET_CURSOR, 8'h00, 40, LAST_ROW, 1, 40, LAST_ROW);
        add_line(OP_PUT, CHAR_LF, 0, 0, 1, 40, LAST_ROW);
        // line feed mid-screen only moves down
        add_line(OP_SET_CURSOR, 8'h00, 5, 0, 1, 5, 0);
        add_line(OP_PUT, CHAR_LF, 0, 0, 1, 5, 1);
        add_line(OP_PUT, 8'h41, 0, 0);
        add_line(OP_PUT, 8'h80, 0, 0);
        add_line(OP_READ, CHAR_CR, 5, 1);
        add_line(OP_READ, 8'h00, LAST_COL, 0);
        // clear ignores its fields and homes the cursor
        add_line(OP_CLEAR, 8'hFF, 127, -128, 1, 0, 0);
        add_line(OP_READ, 8'h00, 6, 1, 1, 0, 0, BLANK_CHAR, RESET_ATTR);
        add_line(OP_PUT, CHAR_CR, 0, 0, 1, 0, 0);

        foreach (script[i])
            send_command(script[i].cmd, script[i].pinned, script[i].res);

        // Random phases, one attribute setting each; last one runs flat out.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_attribute(attr_plan[phase]);
            if (phase == PHASE_COUNT - 1)
            begin
                idle_en  = 1'b0;
                stall_en = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    idle_pct = $urandom_range(0, 2) * 20;
                send_command(random_command(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d result beats checked, %0d attribute writes",
                 cmd_count, result_count, attr_writes);
        $display("covered %0d cell reads, %0d scrolls, %0d screen clears",
                 read_count, scroll_count, clear_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
